// ===== sv/gas_sensor_curve_ppm_assert.svh =====
// ----------------------------------------------------------------------------
// gas sensor curve ppm assertion macros
// shared property forms for the block checks
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_CURVE_PPM_ASSERT_SVH
`define GAS_SENSOR_CURVE_PPM_ASSERT_SVH

// same-cycle implication
`define GSCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gas sensor curve check failed");

// next-cycle implication
`define GSCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gas sensor curve check failed");

`endif

// ===== sv/gscp_pkg.sv =====
// ----------------------------------------------------------------------------
// gscp_pkg
// types, codes and constant tables of the gas sensor curve block
// ----------------------------------------------------------------------------
package gscp_pkg;

  localparam int DIV_W  = 40;
  localparam int DVS_W  = 16;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int LG_W   = 21;
  localparam int EXM_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [19:0] PPM_MAX = 20'hFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_LOAD_RES   = 3'd1,
    REG_CLEAN_AIR  = 3'd2,
    REG_CURVE_CONC = 3'd3,
    REG_CURVE_RAT  = 3'd4,
    REG_SLOPE      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_SAT         = 2'd1,
    STAT_ZERO_PARAM  = 2'd2,
    STAT_ZERO_SAMPLE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RS_DIV,
    S_ACC,
    S_MEAN_DIV,
    S_MEAN_CHK,
    S_RO_DIV,
    S_LOG_MEAN,
    S_LOG_RO,
    S_NUM,
    S_E_DIV,
    S_T_MUL,
    S_EXP_SEL,
    S_EXP,
    S_FIN
  } top_st_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } log_st_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } lg_req_t;

  typedef struct packed {
    logic            done;
    logic [LG_W-1:0] result;
  } lg_rsp_t;

  typedef struct packed {
    logic        start;
    logic [15:0] frac;
  } ex_req_t;

  typedef struct packed {
    logic             done;
    logic [EXM_W-1:0] mant;
  } ex_rsp_t;

  // 2^(2^-(k+1)) in q30
  function automatic logic [EXM_W-1:0] exp2_tab(input logic [3:0] k);
    logic [EXM_W-1:0] v;
    case (k)
      4'd0:    v = 31'd1518500250;
      4'd1:    v = 31'd1276901417;
      4'd2:    v = 31'd1170923762;
      4'd3:    v = 31'd1121280437;
      4'd4:    v = 31'd1097253707;
      4'd5:    v = 31'd1085434098;
      4'd6:    v = 31'd1079572136;
      4'd7:    v = 31'd1076653034;
      4'd8:    v = 31'd1075196443;
      4'd9:    v = 31'd1074468888;
      4'd10:   v = 31'd1074105294;
      4'd11:   v = 31'd1073923544;
      4'd12:   v = 31'd1073832680;
      4'd13:   v = 31'd1073787251;
      4'd14:   v = 31'd1073764537;
      default: v = 31'd1073753181;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/gscp_div.sv =====
// ----------------------------------------------------------------------------
// gscp_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gscp_div
  import gscp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    trial_sub;
  logic              q_bit;

  always_comb begin
    trial     = {rem_r, quo_r[DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    q_bit     = (trial >= {1'b0, dvs_r});
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DCNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], q_bit};
      rem_nxt = q_bit ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== sv/gscp_log2.sv =====
// ----------------------------------------------------------------------------
// gscp_log2
// iterative log2 in q16: shift-normalize, then one squaring per fraction bit
// ----------------------------------------------------------------------------
module gscp_log2
  import gscp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  lg_req_t req,
  output lg_rsp_t rsp
);

  log_st_t     st_r, st_nxt;
  logic [31:0] m_r, m_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] sq;
  logic [32:0] sq_top;

  always_comb begin
    sq       = m_r * m_r;
    sq_top   = sq[63:31];
    st_nxt   = st_r;
    m_nxt    = m_r;
    n_nxt    = n_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    unique case (st_r)
      LG_IDLE: begin
        if (req.start) begin
          m_nxt  = req.value;
          n_nxt  = 5'd31;
          st_nxt = LG_NORM;
        end
      end
      LG_NORM: begin
        if (m_r[31]) begin
          cnt_nxt  = '0;
          frac_nxt = '0;
          st_nxt   = LG_SQ;
        end else begin
          m_nxt = {m_r[30:0], 1'b0};
          n_nxt = n_r - 5'd1;
        end
      end
      LG_SQ: begin
        frac_nxt = {frac_r[14:0], sq_top[32]};
        m_nxt    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          done_nxt = 1'b1;
          st_nxt   = LG_IDLE;
        end
      end
      default: st_nxt = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LG_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    n_r    <= n_nxt;
    frac_r <= frac_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = {n_r, frac_r};

endmodule

// ===== sv/gscp_exp2.sv =====
// ----------------------------------------------------------------------------
// gscp_exp2
// 2^frac in q30, one fraction bit and one table factor per cycle
// ----------------------------------------------------------------------------
module gscp_exp2
  import gscp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  ex_req_t req,
  output ex_rsp_t rsp
);

  logic [EXM_W-1:0]   m_r, m_nxt;
  logic [15:0]        f_r, f_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [2*EXM_W-1:0] prod;

  always_comb begin
    prod     = m_r * exp2_tab(idx_r);
    m_nxt    = m_r;
    f_nxt    = f_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      m_nxt    = EXM_W'(1) << 30;
      f_nxt    = req.frac;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (f_r[15]) begin
        m_nxt = prod[30+EXM_W-1:30];
      end
      f_nxt   = {f_r[14:0], 1'b0};
      idx_nxt = idx_r + 4'd1;
      if (idx_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    f_r <= f_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.mant = m_r;

endmodule

// ===== sv/gas_sensor_curve_ppm.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_curve_ppm
// gas sensor resistance window, calibration and log-log ppm curve
// ----------------------------------------------------------------------------
// usage:
//   in channel takes one adc sample per item (valid/stall); in_stall is high
//   while an item is being worked on, the block takes one item at a time.
//   an ordinary sample passes through the 40-bit bit-serial divider that
//   forms the sensor resistance; a zero sample skips that division.
//   the sample that closes a window of SAMPLES items adds the mean division
//   and then either the ro division in calibrate mode or two passes of the
//   log2 unit, a division and the exp2 unit in measure mode; a zero
//   parameter, a zero mean or an out-of-range exponent cuts this short.
//   out channel gives one item per window from an output register; the next
//   sample is taken while it waits, and a later window result waits in the
//   final step while out_stall holds the earlier one.
//   reset (synchronous, rst_n low) clears the window, ro and out_valid,
//   and loads the register defaults. config writes take effect at once and
//   never restart the window.
// ----------------------------------------------------------------------------
module gas_sensor_curve_ppm
  import gscp_pkg::*;
#(
  parameter int SAMPLES  = 50,
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [11:0]           in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [19:0]           out_concentration_ppm,
  output logic [31:0]           out_ro_value,
  output logic                  out_is_calibration,
  output logic [1:0]            out_status
);

  localparam logic [ADC_BITS-1:0] FS = '1;
  localparam int RLP_W = ADC_BITS + 8;
  localparam logic signed [30:0] LOG10_2_Q30 = 31'sd323228497;
  localparam logic signed [30:0] LOG2_10_Q28 = 31'sd891723284;
  localparam logic signed [35:0] E_LIM = 36'sd2097152;

  // configuration
  logic        mode_r;
  logic [7:0]  load_res_r;
  logic [15:0] caf_r;
  logic [15:0] curve_x_r;
  logic [15:0] curve_y_r;
  logic [15:0] slope_r;

  // control state
  top_st_t     state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [37:0] sum_r, sum_nxt;
  logic [31:0] ro_r, ro_nxt;
  logic        zs_r, zs_nxt;
  logic        out_valid_r, out_valid_nxt;

  // working payload
  logic [31:0]        rs_r, rs_nxt;
  logic [31:0]        mean_r, mean_nxt;
  logic [LG_W-1:0]    lgm_r, lgm_nxt;
  logic signed [55:0] prod_r, prod_nxt;
  logic               neg_r, neg_nxt;
  logic signed [22:0] e_r, e_nxt;
  logic [5:0]         sh_r, sh_nxt;
  logic               sat_r, sat_nxt;
  logic [19:0]        ppm_r, ppm_nxt;
  logic [19:0]        out_ppm_r, out_ppm_nxt;
  logic [31:0]        out_ro_r, out_ro_nxt;
  logic               out_cal_r, out_cal_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;
  lg_req_t  lg_req;
  lg_rsp_t  lg_rsp;
  ex_req_t  ex_req;
  ex_rsp_t  ex_rsp;

  logic [ADC_BITS-1:0] adc;
  logic [RLP_W-1:0]    rl_prod;
  logic [37:0]         sum_add;
  logic [31:0]         quo_sat;
  logic signed [21:0]  lg_diff;
  logic signed [22:0]  lr;
  logic signed [22:0]  num;
  logic [22:0]         num_abs;
  logic [15:0]         slope_abs;
  logic signed [35:0]  q_s;
  logic signed [35:0]  e_full;
  logic signed [25:0]  t_val;
  logic signed [9:0]   ip;
  logic signed [9:0]   sh_full;
  logic                slope_zero;
  status_t             stat;

  gscp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  gscp_log2 u_log2 (
    .clk (clk),
    .rst_n (rst_n),
    .req (lg_req),
    .rsp (lg_rsp)
  );

  gscp_exp2 u_exp2 (
    .clk (clk),
    .rst_n (rst_n),
    .req (ex_req),
    .rsp (ex_rsp)
  );

  always_comb begin
    adc        = ADC_BITS'(in_adc_sample);
    rl_prod    = RLP_W'(load_res_r) * RLP_W'(FS - adc);
    sum_add    = sum_r + 38'(rs_r);
    quo_sat    = (div_rsp.quotient[DIV_W-1:32] != '0) ? '1 : div_rsp.quotient[31:0];
    lg_diff    = $signed({1'b0, lgm_r}) - $signed({1'b0, lg_rsp.result});
    lr         = prod_r[52:30];
    num        = lr - {{3{curve_y_r[15]}}, curve_y_r, 4'b0};
    num_abs    = num[22] ? 23'(-num) : num;
    slope_abs  = slope_r[15] ? 16'(-slope_r) : slope_r;
    slope_zero = (slope_r == '0);
    q_s        = neg_r ? -$signed({1'b0, div_rsp.quotient[34:0]})
                       : $signed({1'b0, div_rsp.quotient[34:0]});
    e_full     = q_s + $signed({{16{curve_x_r[15]}}, curve_x_r, 4'b0});
    t_val      = prod_r[53:28];
    ip         = t_val[25:16];
    sh_full    = 10'sd30 - ip;

    if (mode_r) begin
      if (ro_r == '0) begin
        stat = STAT_ZERO_PARAM;
      end else if (zs_r) begin
        stat = STAT_ZERO_SAMPLE;
      end else begin
        stat = STAT_OK;
      end
    end else begin
      if (ro_r == '0 || slope_zero) begin
        stat = STAT_ZERO_PARAM;
      end else if (zs_r) begin
        stat = STAT_ZERO_SAMPLE;
      end else if (sat_r) begin
        stat = STAT_SAT;
      end else begin
        stat = STAT_OK;
      end
    end

    div_req       = '0;
    lg_req        = '0;
    ex_req        = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    ro_nxt        = ro_r;
    zs_nxt        = zs_r;
    rs_nxt        = rs_r;
    mean_nxt      = mean_r;
    lgm_nxt       = lgm_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    e_nxt         = e_r;
    sh_nxt        = sh_r;
    sat_nxt       = sat_r;
    ppm_nxt       = ppm_r;
    out_ppm_nxt   = out_ppm_r;
    out_ro_nxt    = out_ro_r;
    out_cal_nxt   = out_cal_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (adc == '0) begin
            rs_nxt    = '1;
            zs_nxt    = 1'b1;
            state_nxt = S_ACC;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({rl_prod, 16'b0});
            div_req.divisor  = DVS_W'(adc);
            state_nxt        = S_RS_DIV;
          end
        end
      end
      S_RS_DIV: begin
        if (div_rsp.done) begin
          rs_nxt    = quo_sat;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_nxt == 6'(SAMPLES)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(sum_add);
          div_req.divisor  = DVS_W'(SAMPLES);
          state_nxt        = S_MEAN_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MEAN_DIV: begin
        if (div_rsp.done) begin
          mean_nxt  = quo_sat;
          state_nxt = S_MEAN_CHK;
        end
      end
      S_MEAN_CHK: begin
        sat_nxt = 1'b0;
        ppm_nxt = '0;
        if (mode_r) begin
          if (caf_r == '0) begin
            ro_nxt    = '0;
            state_nxt = S_FIN;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({mean_r, 8'b0});
            div_req.divisor  = caf_r;
            state_nxt        = S_RO_DIV;
          end
        end else if (ro_r == '0 || slope_zero) begin
          state_nxt = S_FIN;
        end else if (mean_r == '0) begin
          sat_nxt   = slope_r[15];
          ppm_nxt   = slope_r[15] ? PPM_MAX : '0;
          state_nxt = S_FIN;
        end else begin
          lg_req.start = 1'b1;
          lg_req.value = mean_r;
          state_nxt    = S_LOG_MEAN;
        end
      end
      S_RO_DIV: begin
        if (div_rsp.done) begin
          ro_nxt    = quo_sat;
          state_nxt = S_FIN;
        end
      end
      S_LOG_MEAN: begin
        if (lg_rsp.done) begin
          lgm_nxt      = lg_rsp.result;
          lg_req.start = 1'b1;
          lg_req.value = ro_r;
          state_nxt    = S_LOG_RO;
        end
      end
      S_LOG_RO: begin
        if (lg_rsp.done) begin
          prod_nxt  = lg_diff * LOG10_2_Q30;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        neg_nxt          = num[22] ^ slope_r[15];
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({num_abs, 12'b0});
        div_req.divisor  = slope_abs;
        state_nxt        = S_E_DIV;
      end
      S_E_DIV: begin
        if (div_rsp.done) begin
          if (e_full > E_LIM) begin
            e_nxt = 23'(E_LIM);
          end else if (e_full < -E_LIM) begin
            e_nxt = 23'(-E_LIM);
          end else begin
            e_nxt = e_full[22:0];
          end
          state_nxt = S_T_MUL;
        end
      end
      S_T_MUL: begin
        prod_nxt  = e_r * LOG2_10_Q28;
        state_nxt = S_EXP_SEL;
      end
      S_EXP_SEL: begin
        if (ip >= 10'sd20) begin
          sat_nxt   = 1'b1;
          ppm_nxt   = PPM_MAX;
          state_nxt = S_FIN;
        end else if (ip < -10'sd31) begin
          state_nxt = S_FIN;
        end else begin
          sh_nxt      = sh_full[5:0];
          ex_req.start = 1'b1;
          ex_req.frac  = t_val[15:0];
          state_nxt    = S_EXP;
        end
      end
      S_EXP: begin
        if (ex_rsp.done) begin
          ppm_nxt   = 20'(ex_rsp.mant >> sh_r);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ppm_nxt   = (mode_r || stat == STAT_ZERO_PARAM) ? '0 : ppm_r;
          out_ro_nxt    = ro_r;
          out_cal_nxt   = mode_r;
          out_stat_nxt  = stat;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          zs_nxt        = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      ro_r        <= '0;
      zs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      ro_r        <= ro_nxt;
      zs_r        <= zs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      load_res_r <= 8'd10;
      caf_r      <= 16'd2358;
      curve_x_r  <= 16'd9421;
      curve_y_r  <= 16'd3809;
      slope_r    <= 16'hE8F6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode_r     <= cfg_data[0];
        REG_LOAD_RES:   load_res_r <= cfg_data[7:0];
        REG_CLEAN_AIR:  caf_r      <= cfg_data;
        REG_CURVE_CONC: curve_x_r  <= cfg_data;
        REG_CURVE_RAT:  curve_y_r  <= cfg_data;
        REG_SLOPE:      slope_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rs_r       <= rs_nxt;
    mean_r     <= mean_nxt;
    lgm_r      <= lgm_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    e_r        <= e_nxt;
    sh_r       <= sh_nxt;
    sat_r      <= sat_nxt;
    ppm_r      <= ppm_nxt;
    out_ppm_r  <= out_ppm_nxt;
    out_ro_r   <= out_ro_nxt;
    out_cal_r  <= out_cal_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_concentration_ppm = out_ppm_r;
  assign out_ro_value          = out_ro_r;
  assign out_is_calibration    = out_cal_r;
  assign out_status            = out_stat_r;

endmodule

// ===== sv/gscp_chk.sv =====
// ----------------------------------------------------------------------------
// gscp_chk
// port-level checks of the gas sensor curve block, bound to the top level
// ----------------------------------------------------------------------------
`include "gas_sensor_curve_ppm_assert.svh"

module gscp_chk
  import gscp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] out_concentration_ppm,
  input logic [31:0] out_ro_value,
  input logic        out_is_calibration,
  input logic [1:0]  out_status
);

  `GSCP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_ro_value) && $stable(out_concentration_ppm))
  `GSCP_ASSERT_IMP(a_cal_ppm, clk, rst_n, out_valid && out_is_calibration, out_concentration_ppm == '0 && out_status != STAT_SAT)
  `GSCP_ASSERT_IMP(a_sat_max, clk, rst_n, out_valid && out_status == STAT_SAT, out_concentration_ppm == PPM_MAX)
  `GSCP_ASSERT_IMP(a_cal_ro, clk, rst_n, out_valid && out_is_calibration, (out_ro_value == '0) == (out_status == STAT_ZERO_PARAM))
  `GSCP_ASSERT_IMP(a_busy_rise, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind gas_sensor_curve_ppm gscp_chk u_gscp_chk (.*);
